// ===== rtl/two_finger_touch_gesture_classifier_unit_defines.svh =====
// Assertion macros used by the gesture classifier top module.
`ifndef TWO_FINGER_TOUCH_GESTURE_CLASSIFIER_UNIT_DEFINES_SVH
`define TWO_FINGER_TOUCH_GESTURE_CLASSIFIER_UNIT_DEFINES_SVH

// cond must never hold while out of reset
`define TFTG_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// ante implies cons in the same cycle
`define TFTG_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tftg_pkg.sv =====
// Package: types, constants and codes of the two-finger gesture classifier.
package tftg_pkg;

    localparam int COORD_BITS    = 16;
    localparam int RAW_BITS      = 16;
    localparam int POS_BITS      = 16;
    localparam int HEIGHT_BITS   = 12;
    localparam int ROT_BITS      = 2;
    localparam int EVENT_BITS    = 2;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 12;

    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_BITS-1:0]  CFG_ROTATION      = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0]  CFG_SCREEN_HEIGHT = 1'b1;

    localparam logic [ROT_BITS-1:0]      ROT_SWAP       = 2'd1;
    localparam logic [ROT_BITS-1:0]      ROT_RESET      = 2'd1;
    localparam logic [HEIGHT_BITS-1:0]   HEIGHT_RESET   = 12'd240;
    localparam logic [EVENT_BITS-1:0]    EVT_CONTACT    = 2'd2;

    typedef enum logic [2:0] {
        G_TOUCH_DOWN = 3'd0,
        G_TOUCH_DRAG = 3'd1,
        G_TOUCH_UP   = 3'd2,
        G_PINCH_DOWN = 3'd3,
        G_PINCH_DRAG = 3'd4,
        G_PINCH_UP   = 3'd5
    } t_gesture;

    typedef struct packed {
        logic                  pending;
        logic [EVENT_BITS-1:0] first_event;
        logic [EVENT_BITS-1:0] second_event;
        logic [RAW_BITS-1:0]   first_raw_x;
        logic [RAW_BITS-1:0]   first_raw_y;
        logic [RAW_BITS-1:0]   second_raw_x;
        logic [RAW_BITS-1:0]   second_raw_y;
    } t_in_word;

    typedef struct packed {
        t_gesture              gesture;
        logic [POS_BITS-1:0]   first_pos_x;
        logic [POS_BITS-1:0]   first_pos_y;
        logic [POS_BITS-1:0]   second_pos_x;
        logic [POS_BITS-1:0]   second_pos_y;
        logic                  first_down;
        logic                  second_down;
        logic                  last;
    } t_out_word;

    typedef struct packed {
        logic                     valid;
        logic [CFG_IDX_BITS-1:0]  index;
        logic [CFG_DATA_BITS-1:0] data;
    } t_cfg_wr;

    // up to two result words written into the queue in one cycle
    typedef struct packed {
        logic [1:0] cnt;
        t_out_word  w0;
        t_out_word  w1;
    } t_push;

endpackage

// ===== rtl/two_finger_touch_gesture_classifier_unit.sv =====
// Two-finger touch gesture classifier: one controller report in, zero to two
// gesture words out. A report is taken in any cycle in which the result queue
// has room for two words (o_in_stall low), so reports enter back to back; the
// front end classifies a report and updates the touch state in the cycle it is
// taken. Words leave through a single output register at one word per cycle
// while not stalled; a down, drag or single up makes one word, and a pinch up
// followed by a touch up makes two. The four-entry queue between front and back
// lets reports keep entering while the output side is stalled, until fewer than
// two free entries remain. A report's first word passes through the queue and
// then the output register.
// Reports with the pending flag clear produce nothing and leave state as is.
// Config writes are always ready; index 0 is rotation, index 1 screen height,
// and they are meant to happen only while no words are in flight.
`include "two_finger_touch_gesture_classifier_unit_defines.svh"

module two_finger_touch_gesture_classifier_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // report input
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  tftg_pkg::t_in_word                    i_in_word,
    // gesture word output
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output tftg_pkg::t_out_word                   o_out_word,
    // config write port
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [tftg_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [tftg_pkg::CFG_DATA_BITS-1:0]    i_cfg_data
);

    tftg_pkg::t_cfg_wr    cfg;
    tftg_pkg::t_push      push;
    tftg_pkg::t_out_word  head;
    logic                 head_valid;
    logic                 almost_full;
    logic                 pop;
    logic                 take;

    assign o_cfg_ready = 1'b1;
    assign cfg.valid   = i_cfg_valid;
    assign cfg.index   = i_cfg_index;
    assign cfg.data    = i_cfg_data;

    // stall depends on queue fill only, never on input valid
    assign o_in_stall = almost_full;
    assign take       = i_in_valid && !almost_full;

    tftg_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_take    (take),
        .i_in_word (i_in_word),
        .o_push    (push)
    );

    tftg_queue u_queue (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_pop         (pop),
        .o_head        (head),
        .o_head_valid  (head_valid),
        .o_almost_full (almost_full)
    );

    tftg_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_head_valid (head_valid),
        .o_pop        (pop),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_out_word   (o_out_word)
    );

    // only a pinch up can be followed by another word of the same report
    `TFTG_ASSERT_IMPL(a_nonlast_is_pinch_up, i_clk, i_rst_n, o_out_valid && !o_out_word.last, o_out_word.gesture == tftg_pkg::G_PINCH_UP, "non-final word is not a pinch up")
    // pinch down marks both fingers down
    `TFTG_ASSERT_IMPL(a_pinch_down_marks, i_clk, i_rst_n, o_out_valid && (o_out_word.gesture == tftg_pkg::G_PINCH_DOWN), o_out_word.first_down && o_out_word.second_down && o_out_word.last, "pinch down with finger not marked")
    // touch up always ends a report and clears both marks
    `TFTG_ASSERT_IMPL(a_touch_up_final, i_clk, i_rst_n, o_out_valid && (o_out_word.gesture == tftg_pkg::G_TOUCH_UP), o_out_word.last && !o_out_word.first_down && !o_out_word.second_down, "touch up not final or marks not cleared")
    // a queue that cannot take two words must never be written
    `TFTG_ASSERT_NEVER(a_no_push_when_full, i_clk, i_rst_n, almost_full && (push.cnt != 2'd0), "words pushed into a nearly full queue")

endmodule

// ===== rtl/tftg_front.sv =====
// Front end: config registers, rotation, gesture state and result word generation.
module tftg_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tftg_pkg::t_cfg_wr   i_cfg,
    input  logic                i_take,
    input  tftg_pkg::t_in_word  i_in_word,
    output tftg_pkg::t_push     o_push
);

    logic [tftg_pkg::ROT_BITS-1:0]    r_rotation;
    logic [tftg_pkg::HEIGHT_BITS-1:0] r_screen_height;
    logic                             r_touched, n_touched;
    logic                             r_pinched, n_pinched;
    logic [tftg_pkg::COORD_BITS-1:0]  r_pos_x [2];
    logic [tftg_pkg::COORD_BITS-1:0]  r_pos_y [2];
    logic [tftg_pkg::COORD_BITS-1:0]  n_pos_x [2];
    logic [tftg_pkg::COORD_BITS-1:0]  n_pos_y [2];
    logic                             r_down [2];
    logic                             n_down [2];

    logic [tftg_pkg::COORD_BITS-1:0]  p1x, p1y, p2x, p2y;
    logic                             down1, down2, chg1, chg2;
    tftg_pkg::t_push                  push;

    function automatic logic [2*tftg_pkg::COORD_BITS-1:0] rotate(
        input logic [tftg_pkg::ROT_BITS-1:0]    rot,
        input logic [tftg_pkg::HEIGHT_BITS-1:0] height,
        input logic [tftg_pkg::RAW_BITS-1:0]    rx,
        input logic [tftg_pkg::RAW_BITS-1:0]    ry
    );
        logic [tftg_pkg::COORD_BITS-1:0] x, y;
        x = rx[tftg_pkg::COORD_BITS-1:0];
        y = ry[tftg_pkg::COORD_BITS-1:0];
        if (rot == tftg_pkg::ROT_SWAP) begin
            return {y, tftg_pkg::COORD_BITS'(height) - x};
        end
        return {x, y};
    endfunction

    function automatic tftg_pkg::t_out_word mk_word(
        input tftg_pkg::t_gesture              g,
        input logic [tftg_pkg::COORD_BITS-1:0] ax, ay, bx, by,
        input logic                            da, db
    );
        tftg_pkg::t_out_word w;
        w.gesture      = g;
        w.first_pos_x  = tftg_pkg::POS_BITS'(ax);
        w.first_pos_y  = tftg_pkg::POS_BITS'(ay);
        w.second_pos_x = tftg_pkg::POS_BITS'(bx);
        w.second_pos_y = tftg_pkg::POS_BITS'(by);
        w.first_down   = da;
        w.second_down  = db;
        w.last         = 1'b0;
        return w;
    endfunction

    assign {p1x, p1y} = rotate(r_rotation, r_screen_height,
                               i_in_word.first_raw_x, i_in_word.first_raw_y);
    assign {p2x, p2y} = rotate(r_rotation, r_screen_height,
                               i_in_word.second_raw_x, i_in_word.second_raw_y);

    assign down1 = (i_in_word.first_event  == tftg_pkg::EVT_CONTACT);
    assign down2 = (i_in_word.second_event == tftg_pkg::EVT_CONTACT);
    assign chg1  = (p1x != r_pos_x[0]) || (p1y != r_pos_y[0]);
    assign chg2  = (p2x != r_pos_x[1]) || (p2y != r_pos_y[1]);

    always_comb begin
        n_touched = r_touched;
        n_pinched = r_pinched;
        n_pos_x   = r_pos_x;
        n_pos_y   = r_pos_y;
        n_down    = r_down;
        push      = '0;
        if (i_take && i_in_word.pending) begin
            if (down1 && down2) begin
                if (r_pinched) begin
                    if (chg1 || chg2) begin
                        n_pos_x[0] = p1x; n_pos_y[0] = p1y;
                        n_pos_x[1] = p2x; n_pos_y[1] = p2y;
                        push.w0  = mk_word(tftg_pkg::G_PINCH_DRAG, n_pos_x[0], n_pos_y[0],
                                           n_pos_x[1], n_pos_y[1], n_down[0], n_down[1]);
                        push.cnt = 2'd1;
                    end
                end else begin
                    n_pinched  = 1'b1;
                    n_down[0]  = 1'b1;
                    n_down[1]  = 1'b1;
                    n_pos_x[0] = p1x; n_pos_y[0] = p1y;
                    n_pos_x[1] = p2x; n_pos_y[1] = p2y;
                    push.w0  = mk_word(tftg_pkg::G_PINCH_DOWN, n_pos_x[0], n_pos_y[0],
                                       n_pos_x[1], n_pos_y[1], n_down[0], n_down[1]);
                    push.cnt = 2'd1;
                end
            end else if (down1) begin
                if (r_pinched) begin
                    n_pinched  = 1'b0;
                    n_down[1]  = 1'b0;
                    n_pos_x[1] = p2x; n_pos_y[1] = p2y;
                    push.w0  = mk_word(tftg_pkg::G_PINCH_UP, n_pos_x[0], n_pos_y[0],
                                       n_pos_x[1], n_pos_y[1], n_down[0], n_down[1]);
                    push.cnt = 2'd1;
                end else if (r_touched) begin
                    if (chg1) begin
                        n_pos_x[0] = p1x; n_pos_y[0] = p1y;
                        push.w0  = mk_word(tftg_pkg::G_TOUCH_DRAG, n_pos_x[0], n_pos_y[0],
                                           n_pos_x[1], n_pos_y[1], n_down[0], n_down[1]);
                        push.cnt = 2'd1;
                    end
                end else begin
                    n_touched  = 1'b1;
                    n_down[0]  = 1'b1;
                    n_pos_x[0] = p1x; n_pos_y[0] = p1y;
                    push.w0  = mk_word(tftg_pkg::G_TOUCH_DOWN, n_pos_x[0], n_pos_y[0],
                                       n_pos_x[1], n_pos_y[1], n_down[0], n_down[1]);
                    push.cnt = 2'd1;
                end
            end else begin
                // finger one lifted: pinch up if pinched, then touch up if touched
                if (r_pinched) begin
                    n_pinched  = 1'b0;
                    n_down[1]  = 1'b0;
                    n_pos_x[1] = p2x; n_pos_y[1] = p2y;
                    push.w0  = mk_word(tftg_pkg::G_PINCH_UP, n_pos_x[0], n_pos_y[0],
                                       n_pos_x[1], n_pos_y[1], n_down[0], n_down[1]);
                    push.cnt = 2'd1;
                end
                if (r_touched) begin
                    n_touched  = 1'b0;
                    n_down[0]  = 1'b0;
                    n_pos_x[0] = p1x; n_pos_y[0] = p1y;
                    if (r_pinched) begin
                        push.w1  = mk_word(tftg_pkg::G_TOUCH_UP, n_pos_x[0], n_pos_y[0],
                                           n_pos_x[1], n_pos_y[1], n_down[0], n_down[1]);
                        push.cnt = 2'd2;
                    end else begin
                        push.w0  = mk_word(tftg_pkg::G_TOUCH_UP, n_pos_x[0], n_pos_y[0],
                                           n_pos_x[1], n_pos_y[1], n_down[0], n_down[1]);
                        push.cnt = 2'd1;
                    end
                end
            end
            if (push.cnt == 2'd2) begin
                push.w1.last = 1'b1;
            end else if (push.cnt == 2'd1) begin
                push.w0.last = 1'b1;
            end
        end
    end

    assign o_push = push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rotation      <= tftg_pkg::ROT_RESET;
            r_screen_height <= tftg_pkg::HEIGHT_RESET;
            r_touched       <= 1'b0;
            r_pinched       <= 1'b0;
            r_pos_x[0]      <= '0;
            r_pos_x[1]      <= '0;
            r_pos_y[0]      <= '0;
            r_pos_y[1]      <= '0;
            r_down[0]       <= 1'b0;
            r_down[1]       <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    tftg_pkg::CFG_ROTATION:
                        r_rotation <= i_cfg.data[tftg_pkg::ROT_BITS-1:0];
                    tftg_pkg::CFG_SCREEN_HEIGHT:
                        r_screen_height <= i_cfg.data[tftg_pkg::HEIGHT_BITS-1:0];
                    default: ;
                endcase
            end
            r_touched <= n_touched;
            r_pinched <= n_pinched;
            r_pos_x   <= n_pos_x;
            r_pos_y   <= n_pos_y;
            r_down    <= n_down;
        end
    end

endmodule

// ===== rtl/tftg_queue.sv =====
// Result word queue: takes up to two words a cycle, gives one.
module tftg_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tftg_pkg::t_push      i_push,
    input  logic                 i_pop,
    output tftg_pkg::t_out_word  o_head,
    output logic                 o_head_valid,
    output logic                 o_almost_full
);

    tftg_pkg::t_out_word              r_mem [tftg_pkg::QUEUE_DEPTH];
    logic [tftg_pkg::QPTR_BITS-1:0]   r_wr_ptr, n_wr_ptr;
    logic [tftg_pkg::QPTR_BITS-1:0]   r_rd_ptr, n_rd_ptr;
    logic [tftg_pkg::QCNT_BITS-1:0]   r_count, n_count;
    logic [tftg_pkg::QPTR_BITS-1:0]   wr_ptr_p1;

    assign wr_ptr_p1     = r_wr_ptr + tftg_pkg::QPTR_BITS'(1);
    assign o_head        = r_mem[r_rd_ptr];
    assign o_head_valid  = (r_count != '0);
    // room for two words must remain before a report is taken
    assign o_almost_full = (r_count > tftg_pkg::QCNT_BITS'(tftg_pkg::QUEUE_DEPTH - 2));

    always_comb begin
        n_wr_ptr = r_wr_ptr + tftg_pkg::QPTR_BITS'(i_push.cnt);
        n_rd_ptr = r_rd_ptr + tftg_pkg::QPTR_BITS'(i_pop);
        n_count  = r_count + tftg_pkg::QCNT_BITS'(i_push.cnt)
                 - tftg_pkg::QCNT_BITS'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.w0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[wr_ptr_p1] <= i_push.w1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ===== rtl/tftg_back.sv =====
// Back end: output register draining one queue word per unstalled cycle.
module tftg_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tftg_pkg::t_out_word  i_head,
    input  logic                 i_head_valid,
    output logic                 o_pop,
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output tftg_pkg::t_out_word  o_out_word
);

    logic                r_valid, n_valid;
    tftg_pkg::t_out_word r_word;

    assign o_pop   = i_head_valid && (!r_valid || !i_out_stall);
    assign n_valid = o_pop || (r_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_word <= i_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_word  = r_word;

endmodule

// ===== sim/gesture_checker.sv =====
// Gesture word checker: tracks touch state, predicts gesture words, compares them.
module gesture_checker
    import tftg_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic                     i_in_stall,
    input  t_in_word                 i_in_word,
    input  logic                     i_out_valid,
    input  logic                     i_out_stall,
    input  t_out_word                i_out_word,
    input  logic                     i_cfg_valid,
    input  logic                     i_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    output int                       o_mismatches,
    output int                       o_words_due
);

    logic [ROT_BITS-1:0]    rotation_q;
    logic [HEIGHT_BITS-1:0] height_q;
    logic                   touched_q;
    logic                   pinched_q;
    logic [POS_BITS-1:0]    pos_x_q [2];
    logic [POS_BITS-1:0]    pos_y_q [2];
    logic                   down_q  [2];
    t_out_word              words_due [$];

    initial begin
        o_mismatches = 0;
        o_words_due  = 0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch @%0t: %s got %0h want %0h", $time, what, got, want);
        o_mismatches++;
    endtask

    task automatic check_field(input string what, input int got, input int want);
        if (got != want) report_mismatch(what, got, want);
    endtask

    // display rotation: swap mode maps (x,y) to (y, height - x), 16-bit wrap
    function automatic void place_point(input logic [RAW_BITS-1:0] rx,
                                        input logic [RAW_BITS-1:0] ry,
                                        output logic [POS_BITS-1:0] px,
                                        output logic [POS_BITS-1:0] py);
        if (rotation_q == ROT_SWAP) begin
            px = ry;
            py = {{(POS_BITS-HEIGHT_BITS){1'b0}}, height_q} - rx;
        end else begin
            px = rx;
            py = ry;
        end
    endfunction

    function automatic t_out_word snapshot(input t_gesture g);
        t_out_word w;
        w.gesture      = g;
        w.first_pos_x  = pos_x_q[0];
        w.first_pos_y  = pos_y_q[0];
        w.second_pos_x = pos_x_q[1];
        w.second_pos_y = pos_y_q[1];
        w.first_down   = down_q[0];
        w.second_down  = down_q[1];
        w.last         = 1'b0;
        return w;
    endfunction

    function automatic void classify_report(input t_in_word r);
        logic                d1, d2;
        logic [POS_BITS-1:0] p1x, p1y, p2x, p2y;
        t_out_word           made [2];
        int                  n;
        n = 0;
        if (!r.pending) return;
        d1 = (r.first_event == EVT_CONTACT);
        d2 = (r.second_event == EVT_CONTACT);
        place_point(r.first_raw_x, r.first_raw_y, p1x, p1y);
        place_point(r.second_raw_x, r.second_raw_y, p2x, p2y);
        if (d1 && d2) begin
            if (pinched_q) begin
                if (p1x != pos_x_q[0] || p1y != pos_y_q[0] ||
                    p2x != pos_x_q[1] || p2y != pos_y_q[1]) begin
                    pos_x_q[0] = p1x; pos_y_q[0] = p1y;
                    pos_x_q[1] = p2x; pos_y_q[1] = p2y;
                    made[n++] = snapshot(G_PINCH_DRAG);
                end
            end else begin
                pinched_q = 1'b1;
                down_q[0] = 1'b1; pos_x_q[0] = p1x; pos_y_q[0] = p1y;
                down_q[1] = 1'b1; pos_x_q[1] = p2x; pos_y_q[1] = p2y;
                made[n++] = snapshot(G_PINCH_DOWN);
            end
        end else if (d1 && pinched_q) begin
            pinched_q = 1'b0;
            down_q[1] = 1'b0; pos_x_q[1] = p2x; pos_y_q[1] = p2y;
            made[n++] = snapshot(G_PINCH_UP);
        end else if (d1) begin
            if (touched_q) begin
                if (p1x != pos_x_q[0] || p1y != pos_y_q[0]) begin
                    pos_x_q[0] = p1x; pos_y_q[0] = p1y;
                    made[n++] = snapshot(G_TOUCH_DRAG);
                end
            end else begin
                touched_q = 1'b1;
                down_q[0] = 1'b1; pos_x_q[0] = p1x; pos_y_q[0] = p1y;
                made[n++] = snapshot(G_TOUCH_DOWN);
            end
        end else begin
            // finger one lifted: pinch up, then touch up, possibly both
            if (pinched_q) begin
                pinched_q = 1'b0;
                down_q[1] = 1'b0; pos_x_q[1] = p2x; pos_y_q[1] = p2y;
                made[n++] = snapshot(G_PINCH_UP);
            end
            if (touched_q) begin
                touched_q = 1'b0;
                down_q[0] = 1'b0; pos_x_q[0] = p1x; pos_y_q[0] = p1y;
                made[n++] = snapshot(G_TOUCH_UP);
            end
        end
        if (n > 0) made[n-1].last = 1'b1;
        for (int i = 0; i < n; i++) words_due.push_back(made[i]);
    endfunction

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            rotation_q = ROT_RESET;
            height_q   = HEIGHT_RESET;
            touched_q  = 1'b0;
            pinched_q  = 1'b0;
            for (int i = 0; i < 2; i++) begin
                pos_x_q[i] = '0;
                pos_y_q[i] = '0;
                down_q[i]  = 1'b0;
            end
            words_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ROTATION:      rotation_q = i_cfg_data[ROT_BITS-1:0];
                    CFG_SCREEN_HEIGHT: height_q   = i_cfg_data[HEIGHT_BITS-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (words_due.size() == 0) begin
                    report_mismatch("unexpected word, gesture", int'(i_out_word.gesture), 0);
                end else begin
                    want = words_due.pop_front();
                    check_field("gesture", int'(i_out_word.gesture), int'(want.gesture));
                    check_field("first_pos_x", i_out_word.first_pos_x, want.first_pos_x);
                    check_field("first_pos_y", i_out_word.first_pos_y, want.first_pos_y);
                    check_field("second_pos_x", i_out_word.second_pos_x, want.second_pos_x);
                    check_field("second_pos_y", i_out_word.second_pos_y, want.second_pos_y);
                    check_field("first_down", i_out_word.first_down, want.first_down);
                    check_field("second_down", i_out_word.second_down, want.second_down);
                    check_field("last", i_out_word.last, want.last);
                end
            end
            if (i_in_valid && !i_in_stall) classify_report(i_in_word);
        end
        o_words_due = words_due.size();
    end

endmodule

// ===== sim/tb.sv =====
// Top of the gesture classifier bench: clock, reset, stimulus phases and verdict.
module tb;
    import tftg_pkg::*;

    // Run bounds. The limit leaves a wide margin on top of the slowest legal run.
    localparam int LIMIT_CYCLES = 200000;
    localparam int DRAIN_CYCLES = 16;   // queue depth plus pipeline, with slack
    localparam int PHASE_ITEMS  = 65;   // pending reports per random phase
    localparam int NUM_PHASES   = 8;

    // non-contact controller event codes
    localparam logic [EVENT_BITS-1:0] EVT_PRESS_DOWN = 2'd0;
    localparam logic [EVENT_BITS-1:0] EVT_LIFT_UP    = 2'd1;
    localparam logic [EVENT_BITS-1:0] EVT_NO_EVENT   = 2'd3;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_stall;
    t_in_word                 i_in_word;
    logic                     o_out_valid;
    logic                     i_out_stall;
    t_out_word                o_out_word;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;

    int mismatches;
    int words_due;
    int idle_pct;      // chance per cycle that the sender holds off
    int stall_pct;     // chance per cycle that the receiver stalls

    // per-phase display settings; the extremes of both registers appear
    logic [ROT_BITS-1:0]    phase_rot    [NUM_PHASES] = '{2'd0, 2'd1, 2'd1, 2'd2,
                                                          2'd3, 2'd1, 2'd0, 2'd1};
    logic [HEIGHT_BITS-1:0] phase_height [NUM_PHASES] = '{12'd4095, 12'd1, 12'd4095,
                                                          12'd100, 12'd240, 12'd0,
                                                          12'd1, 12'd320};

    always #5 i_clk = ~i_clk;

    two_finger_touch_gesture_classifier_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    gesture_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_word    (i_in_word),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_word   (o_out_word),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_mismatches (mismatches),
        .o_words_due  (words_due)
    );

    // Receiver back-pressure, redrawn every falling edge (one assignment per step).
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Hard stop in case the block hangs.
    initial begin
        #(LIMIT_CYCLES * 10);
        $display("== FAIL ==");
        $finish;
    end

    function automatic t_in_word make_report(input logic pend,
                                             input logic [EVENT_BITS-1:0] e1,
                                             input logic [EVENT_BITS-1:0] e2,
                                             input logic [RAW_BITS-1:0] x1,
                                             input logic [RAW_BITS-1:0] y1,
                                             input logic [RAW_BITS-1:0] x2,
                                             input logic [RAW_BITS-1:0] y2);
        t_in_word w;
        w.pending      = pend;
        w.first_event  = e1;
        w.second_event = e2;
        w.first_raw_x  = x1;
        w.first_raw_y  = y1;
        w.second_raw_x = x2;
        w.second_raw_y = y2;
        return w;
    endfunction

    // Coordinates: often unchanged so that drags without motion show up,
    // otherwise small, extreme or fully random.
    function automatic logic [RAW_BITS-1:0] random_coord(input logic [RAW_BITS-1:0] old);
        int r;
        r = $urandom_range(99);
        if (r < 40)      return old;
        else if (r < 65) return RAW_BITS'($urandom);
        else if (r < 80) return RAW_BITS'($urandom_range(300));
        else if (r < 90) return '0;
        else             return '1;
    endfunction

    // Mostly clean contact/no-contact event pairs; some noise codes and
    // some reports with the pending flag clear.
    function automatic t_in_word random_report(input t_in_word prev);
        t_in_word w;
        w = prev;
        w.pending = ($urandom_range(99) >= 8);
        if ($urandom_range(99) < 85) begin
            w.first_event  = $urandom_range(1) ? EVT_CONTACT : EVT_PRESS_DOWN;
            w.second_event = $urandom_range(1) ? EVT_CONTACT : EVT_PRESS_DOWN;
        end else begin
            w.first_event  = EVENT_BITS'($urandom_range(3));
            w.second_event = EVENT_BITS'($urandom_range(3));
        end
        w.first_raw_x  = random_coord(prev.first_raw_x);
        w.first_raw_y  = random_coord(prev.first_raw_y);
        w.second_raw_x = random_coord(prev.second_raw_x);
        w.second_raw_y = random_coord(prev.second_raw_y);
        return w;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    // with valid still high, so back-to-back reports drop valid only on hold-off.
    task automatic push_report(input t_in_word w);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    // Lower valid and wait for every predicted word to come out.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (words_due != 0);
    endtask

    // Leaves valid high; the caller lowers it after the last write.
    task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx,
                                  input logic [CFG_DATA_BITS-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    initial begin
        t_in_word prev;
        int       sent;

        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_word   = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        idle_pct    = 0;
        stall_pct   = 0;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // ---- directed part, reset settings (swap rotation, height 240) ----
        // report with pending clear: must be ignored even with contact codes
        push_report(make_report(1'b0, EVT_CONTACT, EVT_CONTACT, 16'd5, 16'd6, 16'd7, 16'd8));
        // touch down at the origin, then a drag with no motion (no word)
        push_report(make_report(1'b1, EVT_CONTACT, EVT_PRESS_DOWN, 16'h0000, 16'h0000,
                                16'h0000, 16'h0000));
        push_report(make_report(1'b1, EVT_CONTACT, EVT_LIFT_UP, 16'h0000, 16'h0000,
                                16'hFFFF, 16'hFFFF));
        // drag to the far corner: wraps in the height subtraction
        push_report(make_report(1'b1, EVT_CONTACT, EVT_NO_EVENT, 16'hFFFF, 16'hFFFF,
                                16'h1234, 16'h5678));
        // pinch down while touched; touched flag stays set
        push_report(make_report(1'b1, EVT_CONTACT, EVT_CONTACT, 16'hFFFF, 16'hFFFF,
                                16'h00F0, 16'h0001));
        // pinch drag without motion, then with motion of finger two only
        push_report(make_report(1'b1, EVT_CONTACT, EVT_CONTACT, 16'hFFFF, 16'hFFFF,
                                16'h00F0, 16'h0001));
        push_report(make_report(1'b1, EVT_CONTACT, EVT_CONTACT, 16'hFFFF, 16'hFFFF,
                                16'h00F1, 16'h0001));
        // finger two lifts during pinch: pinch up only
        push_report(make_report(1'b1, EVT_CONTACT, EVT_LIFT_UP, 16'h8000, 16'h7FFF,
                                16'hAAAA, 16'h5555));
        // finger one lifts while touched: touch up
        push_report(make_report(1'b1, EVT_LIFT_UP, EVT_PRESS_DOWN, 16'h0100, 16'h0200,
                                16'h0000, 16'h0000));
        // pinch without a prior touch, then both lift: pinch up alone
        push_report(make_report(1'b1, EVT_CONTACT, EVT_CONTACT, 16'h0010, 16'h0020,
                                16'h0030, 16'h0040));
        push_report(make_report(1'b1, EVT_NO_EVENT, EVT_NO_EVENT, 16'h0011, 16'h0021,
                                16'h0031, 16'h0041));
        // touch, pinch, both lift: pinch up followed by touch up in one report
        push_report(make_report(1'b1, EVT_CONTACT, EVT_PRESS_DOWN, 16'h0005, 16'h0006,
                                16'h0000, 16'h0000));
        push_report(make_report(1'b1, EVT_CONTACT, EVT_CONTACT, 16'h0005, 16'h0006,
                                16'h0050, 16'h0060));
        push_report(make_report(1'b1, EVT_PRESS_DOWN, EVT_LIFT_UP, 16'hFFFF, 16'h0000,
                                16'h0000, 16'hFFFF));
        // finger two alone down while touched: handled as finger one lifted
        push_report(make_report(1'b1, EVT_CONTACT, EVT_NO_EVENT, 16'h0777, 16'h0888,
                                16'h0000, 16'h0000));
        push_report(make_report(1'b1, EVT_LIFT_UP, EVT_CONTACT, 16'h0999, 16'h0AAA,
                                16'h0BBB, 16'h0CCC));
        // finger two alone while pinched: pinch up, no touch up
        push_report(make_report(1'b1, EVT_CONTACT, EVT_CONTACT, 16'h1111, 16'h2222,
                                16'h3333, 16'h4444));
        push_report(make_report(1'b1, EVT_PRESS_DOWN, EVT_CONTACT, 16'h5555, 16'h6666,
                                16'h7777, 16'h8888));
        // lift with nothing down: no word
        push_report(make_report(1'b1, EVT_NO_EVENT, EVT_LIFT_UP, 16'h0001, 16'h0002,
                                16'h0003, 16'h0004));
        prev = make_report(1'b1, EVT_PRESS_DOWN, EVT_PRESS_DOWN, 16'h0001, 16'h0002,
                           16'h0003, 16'h0004);

        // ---- random phases, new display settings before each ----
        for (int p = 0; p < NUM_PHASES; p++) begin
            // registers change only with the block idle; the settle time after the
            // drain is extra margin, as every report is classified when it is taken
            wait_drained();
            repeat (DRAIN_CYCLES) @(negedge i_clk);
            write_register(CFG_ROTATION, CFG_DATA_BITS'(phase_rot[p]));
            write_register(CFG_SCREEN_HEIGHT, CFG_DATA_BITS'(phase_height[p]));
            i_cfg_valid <= 1'b0;

            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 59; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 59; end
                default: begin idle_pct = 15; stall_pct = 15; end
            endcase

            sent = 0;
            while (sent < PHASE_ITEMS) begin
                // mid-phase hold-off in stall-heavy phases until everything predicted has come out
                if (sent == PHASE_ITEMS / 2 && (p % 4) == 2) wait_drained();
                prev = random_report(prev);
                push_report(prev);
                if (prev.pending) sent++;
            end
        end

        // ---- wind down ----
        wait_drained();
        stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && words_due == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/tftg_pkg.sv
rtl/tftg_front.sv
rtl/tftg_queue.sv
rtl/tftg_back.sv
rtl/two_finger_touch_gesture_classifier_unit.sv
sim/gesture_checker.sv
sim/tb.sv
